/* hdl/pcb_pkg.sv */
// Package for the PCI type-0 configuration header with BAR sizing.
// Holds shared types and codes; depends on nothing.
`default_nettype none
package pcb_pkg;
  localparam int NumBars = 6;
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_IO    = 2'd1;
  localparam logic [1:0] KIND_MEM32 = 2'd2;
  localparam logic [1:0] KIND_MEM64 = 2'd3;
  // Effective BAR kinds, with the high dword of a 64-bit BAR as its own code.
  localparam logic [2:0] EK_NONE  = 3'd0;
  localparam logic [2:0] EK_IO    = 3'd1;
  localparam logic [2:0] EK_MEM32 = 3'd2;
  localparam logic [2:0] EK_MEM64 = 3'd3;
  localparam logic [2:0] EK_HIGH  = 3'd4;
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_MAP   = 2'd1;
  localparam logic [1:0] EV_UNMAP = 2'd2;
  localparam logic [2:0] REG_VDID = 3'd0;
  localparam logic [2:0] REG_SSID = 3'd1;
  localparam logic [2:0] REG_CLRV = 3'd2;
  localparam logic [2:0] REG_IPIN = 3'd3;
  localparam logic [2:0] REG_KIND = 3'd4;
  localparam logic [2:0] REG_SLOG = 3'd5;
  localparam logic [2:0] REG_PREF = 3'd6;

  typedef enum logic [1:0] {ST_IDLE, ST_ACCESS, ST_WALK, ST_DONE} state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       do_access;
    logic       walk_step;
    logic       emit_idle;
  } ctl_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic       need_walk;
    logic       walk_done;
  } ctl_sts_t;
endpackage
`default_nettype wire

/* hdl/pcb_ctrl.sv */
// Controller state machine for the configuration header block.
// Depends on pcb_pkg.
`default_nettype none
module pcb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output pcb_pkg::ctl_cmd_t  cmd,
  input  pcb_pkg::ctl_sts_t  sts
);
  pcb_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pcb_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != pcb_pkg::ST_IDLE);
    unique case (state_r)
      pcb_pkg::ST_IDLE: begin
        if (start) state_nxt = pcb_pkg::ST_ACCESS;
      end
      pcb_pkg::ST_ACCESS: begin
        cmd.do_access = 1'b1;
        state_nxt = pcb_pkg::ST_WALK;
      end
      pcb_pkg::ST_WALK: begin
        if (sts.need_walk) begin
          cmd.walk_step = 1'b1;
          if (sts.walk_done) state_nxt = pcb_pkg::ST_IDLE;
        end else begin
          state_nxt = pcb_pkg::ST_DONE;
        end
      end
      pcb_pkg::ST_DONE: begin
        cmd.emit_idle = 1'b1;
        state_nxt = pcb_pkg::ST_IDLE;
      end
      default: state_nxt = pcb_pkg::ST_IDLE;
    endcase
  end

  a_cmd_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_access, cmd.walk_step, cmd.emit_idle}))
    else $error("more than one command at once");
  a_access_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> cmd.do_access)
    else $error("access did not follow accepted start");
  a_busy_after_access: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_access |=> busy)
    else $error("controller left busy too early");
endmodule
`default_nettype wire

/* hdl/pcb_dpath.sv */
// Datapath: header state, BAR registers, access decode and the BAR walk.
// Depends on pcb_pkg.
`default_nettype none
module pcb_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire logic          in_command,
  input  wire logic [7:0]    in_byte_offset,
  input  wire logic [2:0]    in_access_size,
  input  wire logic [31:0]   in_write_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_idx,
  input  wire logic [31:0]   cfg_wdata,
  output logic [31:0]        cfg_rdata,
  input  pcb_pkg::ctl_cmd_t  cmd,
  output pcb_pkg::ctl_sts_t  sts,
  output logic               out_valid,
  output logic [31:0]        out_read_data,
  output logic [1:0]         out_event_kind,
  output logic [2:0]         out_event_bar,
  output logic [63:0]        out_event_address,
  output logic [4:0]         out_event_size_log,
  output logic               out_last
);
  localparam int NB = pcb_pkg::NumBars;

  // Configuration registers.
  logic [31:0] vdid_r, ssid_r, clrv_r;
  logic [7:0]  ipin_r;
  logic [11:0] kinds_r;
  logic [29:0] slogs_r;
  logic [5:0]  pref_r;

  // Header and BAR state.
  logic [15:0] cmdw_r;
  logic [7:0]  cls_r, lat_r, irq_r;
  logic [31:0] lo_r [6];
  logic [31:0] hi_r [6];
  logic [5:0]  mapped_r;
  logic [63:0] maddr_r [6];

  // Latched item.
  logic        wr_r;
  logic [7:0]  off_r;
  logic [2:0]  size_r;
  logic [31:0] wdata_r;

  // Walk state.
  logic        walk_r;
  logic [2:0]  widx_r;
  logic        pend_map_r;

  // Output registers.
  logic        ov_r, olast_r;
  logic [31:0] ord_r;
  logic [1:0]  okind_r;
  logic [2:0]  obar_r;
  logic [63:0] oaddr_r;
  logic [4:0]  olog_r;

  // Effective kinds; a slot after a 64-bit BAR is its high dword.
  logic [2:0] ekind [6];
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      if (j >= NB) ekind[j] = pcb_pkg::EK_NONE;
      else if (j > 0 && ekind[j-1] == pcb_pkg::EK_MEM64) ekind[j] = pcb_pkg::EK_HIGH;
      else ekind[j] = {1'b0, kinds_r[2*j +: 2]};
    end
  end

  function automatic logic [31:0] lmask(input logic [2:0] k, input logic [4:0] lg);
    logic [31:0] m;
    m = ~((32'd1 << lg) - 32'd1);
    if (k == pcb_pkg::EK_IO) return m & 32'hFFFF_FFFC;
    if (k == pcb_pkg::EK_MEM32 || k == pcb_pkg::EK_MEM64)
      return m & 32'hFFFF_FFF0;
    return 32'd0;
  endfunction

  // Access decode.
  logic        ok, in_space, in_bar, bar_one;
  logic [8:0]  endo;
  logic [4:0]  roff;
  logic [2:0]  bidx, bidx_last;
  logic [1:0]  bsub;
  logic [31:0] smask, wmask;
  always_comb begin
    ok = (size_r == 3'd1) || (size_r == 3'd2) || (size_r == 3'd4);
    endo = {1'b0, off_r} + {6'd0, size_r};
    in_space = endo <= 9'd256;
    in_bar = ok && off_r >= 8'h10 && endo <= 9'h28;
    roff = 5'(off_r - 8'h10);
    bidx = roff[4:2];
    bsub = roff[1:0];
    bidx_last = 3'(5'(endo - 9'h11) >> 2);
    bar_one = in_bar && bidx == bidx_last;
    unique case (size_r)
      3'd1: smask = 32'h0000_00FF;
      3'd2: smask = 32'h0000_FFFF;
      3'd4: smask = 32'hFFFF_FFFF;
      default: smask = 32'h0;
    endcase
    wmask = smask << {bsub, 3'b000};
  end

  // BAR read of the selected dword and the spliced write value.
  logic [31:0] bar_rd, bar_cur, bar_new;
  logic [2:0]  bk;
  logic [31:0] bm;
  always_comb begin
    bk = ekind[bidx];
    bm = lmask(bk, slogs_r[5*bidx +: 5]);
    unique case (bk)
      pcb_pkg::EK_IO: bar_rd = (lo_r[bidx] & bm) | 32'd1;
      pcb_pkg::EK_MEM32: bar_rd = (lo_r[bidx] & bm) | (pref_r[bidx] ? 32'd8 : 32'd0);
      pcb_pkg::EK_MEM64:
        bar_rd = (lo_r[bidx] & bm) | 32'd4 | (pref_r[bidx] ? 32'd8 : 32'd0);
      pcb_pkg::EK_HIGH: bar_rd = hi_r[3'(bidx - 3'd1)];
      default: bar_rd = 32'd0;
    endcase
    bar_cur = (bk == pcb_pkg::EK_HIGH) ? hi_r[3'(bidx - 3'd1)] : (bar_rd & bm);
    bar_new = (bar_cur & ~wmask) | ((wdata_r << {bsub, 3'b000}) & wmask);
  end

  // Header byte reads and writes.
  function automatic logic [7:0] hbyte(input logic [8:0] o, input logic [31:0] vd,
      input logic [15:0] cw, input logic [31:0] cr, input logic [7:0] c0,
      input logic [7:0] c1, input logic [31:0] ss, input logic [7:0] c2,
      input logic [7:0] ip);
    if (o < 9'd4) return vd[8*o[1:0] +: 8];
    if (o < 9'd6) return cw[8*o[0] +: 8];
    if (o >= 9'd8 && o < 9'd12) return cr[8*o[1:0] +: 8];
    if (o == 9'h0C) return c0;
    if (o == 9'h0D) return c1;
    if (o >= 9'h2C && o < 9'h30) return ss[8*o[1:0] +: 8];
    if (o == 9'h3C) return c2;
    if (o == 9'h3D) return ip;
    return 8'd0;
  endfunction

  logic [31:0] plain_rd, rd_val;
  logic [15:0] cmdw_w;
  logic [7:0]  cls_w, lat_w, irq_w;
  logic [8:0]  bo;
  always_comb begin
    plain_rd = '0;
    cmdw_w = cmdw_r; cls_w = cls_r; lat_w = lat_r; irq_w = irq_r;
    for (int b = 0; b < 4; b++) begin
      bo = {1'b0, off_r} + 9'(b);
      if (3'(b) < size_r) begin
        plain_rd[8*b +: 8] = hbyte(bo, vdid_r, cmdw_r, clrv_r, cls_r, lat_r, ssid_r,
                                   irq_r, ipin_r);
        if (bo == 9'd4) cmdw_w[7:0] = wdata_r[8*b +: 8];
        if (bo == 9'd5) cmdw_w[15:8] = wdata_r[8*b +: 8];
        if (bo == 9'h0C) cls_w = wdata_r[8*b +: 8];
        if (bo == 9'h0D) lat_w = wdata_r[8*b +: 8];
        if (bo == 9'h3C) irq_w = wdata_r[8*b +: 8];
      end
    end
    if (!ok) rd_val = '0;
    else if (!in_space) rd_val = smask;
    else if (bar_one) rd_val = (bar_rd >> {bsub, 3'b000}) & smask;
    else rd_val = plain_rd;
  end

  // Walk evaluation of the current BAR.
  logic [2:0]  wk;
  logic [63:0] gpa;
  logic        want, is_mem, ev_unmap, ev_map, ev_remap;
  always_comb begin
    wk = ekind[widx_r];
    is_mem = (wk == pcb_pkg::EK_MEM32) || (wk == pcb_pkg::EK_MEM64);
    gpa = {32'd0, lo_r[widx_r] & 32'hFFFF_FFF0};
    if (wk == pcb_pkg::EK_MEM64) gpa[63:32] = hi_r[widx_r];
    want = cmdw_r[1] && gpa != 64'd0;
    ev_map = is_mem && want && !mapped_r[widx_r];
    ev_unmap = is_mem && !want && mapped_r[widx_r];
    ev_remap = is_mem && want && mapped_r[widx_r] && maddr_r[widx_r] != gpa;
  end

  // Whether any BAR after the current one still has an event due.
  logic        any_later;
  logic [63:0] lgpa [6];
  logic        lwant [6];
  always_comb begin
    any_later = 1'b0;
    for (int j = 0; j < 6; j++) begin
      lgpa[j] = {32'd0, lo_r[j] & 32'hFFFF_FFF0};
      if (ekind[j] == pcb_pkg::EK_MEM64) lgpa[j][63:32] = hi_r[j];
      lwant[j] = cmdw_r[1] && lgpa[j] != 64'd0;
      if (3'(j) > widx_r &&
          (ekind[j] == pcb_pkg::EK_MEM32 || ekind[j] == pcb_pkg::EK_MEM64) &&
          (lwant[j] != mapped_r[j] || (lwant[j] && maddr_r[j] != lgpa[j])))
        any_later = 1'b1;
    end
  end

  logic        step_emit, step_adv, last_bar;
  always_comb begin
    last_bar = (widx_r == 3'(NB - 1));
    step_emit = pend_map_r || ev_map || ev_unmap || ev_remap;
    step_adv = !(ev_remap && !pend_map_r);
    sts.need_walk = walk_r;
    sts.walk_done = step_adv && last_bar;
  end

  // Remember whether the walk has emitted anything yet.
  logic emitted_r;

  // Sequential update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vdid_r <= '0; ssid_r <= '0; clrv_r <= '0; ipin_r <= '0;
      kinds_r <= '0; slogs_r <= '0; pref_r <= '0;
      cmdw_r <= '0; cls_r <= '0; lat_r <= '0; irq_r <= '0;
      mapped_r <= '0;
      for (int i = 0; i < 6; i++) begin
        lo_r[i] <= '0; hi_r[i] <= '0; maddr_r[i] <= '0;
      end
      walk_r <= 1'b0; widx_r <= '0; pend_map_r <= 1'b0; emitted_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          pcb_pkg::REG_VDID: vdid_r <= cfg_wdata;
          pcb_pkg::REG_SSID: ssid_r <= cfg_wdata;
          pcb_pkg::REG_CLRV: clrv_r <= cfg_wdata;
          pcb_pkg::REG_IPIN: ipin_r <= cfg_wdata[7:0];
          pcb_pkg::REG_KIND: kinds_r <= cfg_wdata[11:0];
          pcb_pkg::REG_SLOG: slogs_r <= cfg_wdata[29:0];
          pcb_pkg::REG_PREF: pref_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (cmd.do_access) begin
        walk_r <= 1'b0; widx_r <= '0; pend_map_r <= 1'b0; emitted_r <= 1'b0;
        if (!wr_r) begin
          ov_r <= 1'b1; olast_r <= 1'b1; ord_r <= rd_val; okind_r <= pcb_pkg::EV_NONE;
          obar_r <= '0; oaddr_r <= '0; olog_r <= '0;
        end else if (ok && in_space) begin
          // Any write inside the BAR window splices into the BAR of its first byte.
          if (in_bar) begin
            if (bk != pcb_pkg::EK_NONE) begin
              if (bk == pcb_pkg::EK_HIGH) hi_r[3'(bidx - 3'd1)] <= bar_new;
              else lo_r[bidx] <= bar_new & bm;
            end
          end else begin
            cmdw_r <= cmdw_w; cls_r <= cls_w; lat_r <= lat_w; irq_r <= irq_w;
            walk_r <= cmdw_w != cmdw_r;
          end
        end
      end
      if (cmd.walk_step) begin
        if (step_emit) begin
          emitted_r <= 1'b1;
          ov_r <= 1'b1; ord_r <= '0; obar_r <= widx_r;
          olast_r <= step_adv && !any_later;
          if (pend_map_r || ev_map) begin
            okind_r <= pcb_pkg::EV_MAP; oaddr_r <= gpa;
            olog_r <= slogs_r[5*widx_r +: 5];
            mapped_r[widx_r] <= 1'b1; maddr_r[widx_r] <= gpa;
          end else begin
            okind_r <= pcb_pkg::EV_UNMAP; oaddr_r <= '0; olog_r <= '0;
            if (ev_unmap) mapped_r[widx_r] <= 1'b0;
          end
        end else if (step_adv && last_bar && !emitted_r) begin
          // A walk that found nothing to report closes with an idle beat.
          ov_r <= 1'b1; olast_r <= 1'b1; ord_r <= '0; obar_r <= '0;
          oaddr_r <= '0; olog_r <= '0; okind_r <= pcb_pkg::EV_NONE;
        end
        pend_map_r <= ev_remap && !pend_map_r;
        if (step_adv) widx_r <= 3'(widx_r + 3'd1);
        if (step_adv && last_bar) walk_r <= 1'b0;
      end
      if (cmd.emit_idle && wr_r) begin
        ov_r <= 1'b1; olast_r <= 1'b1; ord_r <= '0; okind_r <= pcb_pkg::EV_NONE;
        obar_r <= '0; oaddr_r <= '0; olog_r <= '0;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      wr_r <= in_command; off_r <= in_byte_offset;
      size_r <= in_access_size; wdata_r <= in_write_data;
    end
  end

  // Result ports come straight from the output registers; cfg_rdata is a combinational read of the cfg_idx register.
  always_comb begin
    out_valid = ov_r;
    out_read_data = ord_r; out_event_kind = okind_r; out_event_bar = obar_r;
    out_event_address = oaddr_r; out_event_size_log = olog_r; out_last = olast_r;
    cfg_rdata = '0;
    unique case (cfg_idx)
      pcb_pkg::REG_VDID: cfg_rdata = vdid_r;
      pcb_pkg::REG_SSID: cfg_rdata = ssid_r;
      pcb_pkg::REG_CLRV: cfg_rdata = clrv_r;
      pcb_pkg::REG_IPIN: cfg_rdata = {24'd0, ipin_r};
      pcb_pkg::REG_KIND: cfg_rdata = {20'd0, kinds_r};
      pcb_pkg::REG_SLOG: cfg_rdata = {2'd0, slogs_r};
      pcb_pkg::REG_PREF: cfg_rdata = {26'd0, pref_r};
      default: cfg_rdata = '0;
    endcase
  end

  a_map_has_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && okind_r == pcb_pkg::EV_MAP) |-> oaddr_r != 64'd0)
    else $error("map event with zero base");
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r |-> busy)
    else $error("walk running while idle");
  a_read_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ord_r != 32'd0) |-> okind_r == pcb_pkg::EV_NONE)
    else $error("read result carries an event");
endmodule
`default_nettype wire

/* hdl/pci_config_space_bars.sv */
// Top level of the PCI type-0 configuration header with BAR sizing.
// Depends on pcb_pkg, pcb_ctrl and pcb_dpath.
//
//   channel   handshake             payload
//   in_       start / busy          in_command, in_byte_offset, in_access_size, in_write_data
//   out_      out_valid strobe      out_read_data, out_event_*, out_last
//   cfg_      APB psel/penable      paddr, pwdata, prdata
//
// An accepted access passes through the ACCESS state, where a read result is
// registered, then WALK and DONE, where a plain write result is registered;
// busy drops on the return to IDLE.
// A command write that changes the command word walks the six BAR slots one
// per cycle in WALK, a remap holding its slot for an extra step, and then
// returns to IDLE without passing through DONE.
// Reset is synchronous and clears all header and BAR state.
// Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none
module pci_config_space_bars (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [7:0]  in_byte_offset,
  input  wire logic [2:0]  in_access_size,
  input  wire logic [31:0] in_write_data,
  output logic             out_valid,
  output logic [31:0]      out_read_data,
  output logic [1:0]       out_event_kind,
  output logic [2:0]       out_event_bar,
  output logic [63:0]      out_event_address,
  output logic [4:0]       out_event_size_log,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  pcb_pkg::ctl_cmd_t cmd;
  pcb_pkg::ctl_sts_t sts;
  logic              cfg_we;
  logic              dp_busy;

  // Configuration write strobe.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && paddr[1:0] == 2'b00;

  pcb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(dp_busy), .cmd(cmd), .sts(sts)
  );

  assign busy = dp_busy;

  pcb_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_command(in_command), .in_byte_offset(in_byte_offset),
    .in_access_size(in_access_size), .in_write_data(in_write_data),
    .cfg_we(cfg_we), .cfg_idx(paddr[4:2]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .cmd(cmd), .sts(sts),
    .out_valid(out_valid), .out_read_data(out_read_data),
    .out_event_kind(out_event_kind), .out_event_bar(out_event_bar),
    .out_event_address(out_event_address), .out_event_size_log(out_event_size_log),
    .out_last(out_last)
  );
endmodule
`default_nettype wire

/* test/pci_config_space_bars_tb.sv */
// Testbench for the PCI type-0 configuration header with BAR sizing.
// Depends on pcb_pkg and pci_config_space_bars; predicts every result beat.
`default_nettype none
module pci_config_space_bars_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_HIGH = 3'd4;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  kind;
    logic [2:0]  bar;
    logic [63:0] addr;
    logic [4:0]  slog;
    logic        last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = 1'b0;
  logic [7:0] in_byte_offset = '0;
  logic [2:0] in_access_size = '0;
  logic [31:0] in_write_data = '0;
  logic out_valid;
  logic [31:0] out_read_data;
  logic [1:0] out_event_kind;
  logic [2:0] out_event_bar;
  logic [63:0] out_event_address;
  logic [4:0] out_event_size_log;
  logic out_last;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Model copy of configuration and header state.
  logic [31:0] m_vdid, m_ssid, m_clrv;
  logic [7:0]  m_ipin;
  logic [11:0] m_kinds;
  logic [29:0] m_slogs;
  logic [5:0]  m_pref;
  logic [15:0] m_cmd;
  logic [7:0]  m_scratch [3];
  logic [31:0] m_low [6];
  logic [31:0] m_high [6];
  logic        m_mapped [6];
  logic [63:0] m_maddr [6];

  beat_t expected_beats [$];
  int errors = 0;
  int cycles = 0;

  pci_config_space_bars dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle limit guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("pci_config_space_bars_tb: errors");
      $finish;
    end
  end

  function automatic logic [2:0] eff_kind(int i);
    logic [2:0] prev, k;
    prev = {1'b0, pcb_pkg::KIND_NONE};
    k = {1'b0, pcb_pkg::KIND_NONE};
    for (int j = 0; j <= i; j++) begin
      if (j >= pcb_pkg::NumBars) k = {1'b0, pcb_pkg::KIND_NONE};
      else if (prev == {1'b0, pcb_pkg::KIND_MEM64}) k = KIND_HIGH;
      else k = {1'b0, m_kinds[2*j +: 2]};
      prev = k;
    end
    return k;
  endfunction

  function automatic logic [31:0] bar_mask(int i);
    logic [2:0] k;
    logic [31:0] m;
    k = eff_kind(i);
    m = ~((32'd1 << m_slogs[5*i +: 5]) - 32'd1);
    if (k == {1'b0, pcb_pkg::KIND_IO}) return m & 32'hFFFF_FFFC;
    if (k == {1'b0, pcb_pkg::KIND_MEM32} || k == {1'b0, pcb_pkg::KIND_MEM64})
      return m & 32'hFFFF_FFF0;
    return '0;
  endfunction

  function automatic logic [31:0] bar_value(int i);
    logic [2:0] k;
    logic [31:0] v, pf;
    k = eff_kind(i);
    v = m_low[i] & bar_mask(i);
    pf = m_pref[i] ? 32'd8 : 32'd0;
    if (k == KIND_HIGH) return m_high[i-1];
    if (k == {1'b0, pcb_pkg::KIND_IO}) return v | 32'd1;
    if (k == {1'b0, pcb_pkg::KIND_MEM32}) return v | pf;
    if (k == {1'b0, pcb_pkg::KIND_MEM64}) return v | 32'd4 | pf;
    return '0;
  endfunction

  function automatic logic [7:0] header_byte(int off);
    if (off < 4) return m_vdid[8*off +: 8];
    if (off < 6) return m_cmd[8*(off-4) +: 8];
    if (off >= 8 && off < 12) return m_clrv[8*(off-8) +: 8];
    if (off == 'h0C) return m_scratch[0];
    if (off == 'h0D) return m_scratch[1];
    if (off >= 'h2C && off < 'h30) return m_ssid[8*(off-'h2C) +: 8];
    if (off == 'h3C) return m_scratch[2];
    if (off == 'h3D) return m_ipin;
    return '0;
  endfunction

  function automatic beat_t event_beat(logic [1:0] kind, int bar, logic [63:0] a,
                                       logic [4:0] lg);
    beat_t b;
    b = '0;
    b.kind = kind;
    b.bar = bar[2:0];
    b.addr = a;
    b.slog = lg;
    return b;
  endfunction

  // Predicts the beats of one access and updates the model state.
  task automatic predict_access(logic wr, int off, int size, logic [31:0] data);
    beat_t res [$];
    beat_t b;
    logic ok, in_space, bar_one;
    logic [31:0] smask, r, cur, m;
    logic [15:0] old;
    logic [2:0] k;
    logic [63:0] gpa;
    logic want;
    int bi, bo;
    ok = (size == 1 || size == 2 || size == 4);
    in_space = (off + size <= 256);
    bar_one = 1'b0;
    smask = (size == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * (size & 3))) - 32'd1);
    if (ok && off >= 'h10 && off + size <= 'h28)
      bar_one = ((off - 'h10) / 4) == ((off + size - 1 - 'h10) / 4);
    bi = (off - 'h10) / 4;
    bo = (off - 'h10) % 4;
    if (!wr) begin
      r = '0;
      if (!ok) r = '0;
      else if (!in_space) r = smask;
      else if (bar_one) r = (bar_value(bi) >> (8 * bo)) & smask;
      else for (int i = 0; i < size; i++) r |= 32'(header_byte(off + i)) << (8 * i);
      b = '0;
      b.rdata = r;
      res.push_back(b);
    end else if (ok && in_space) begin
      if (off >= 'h10 && off + size <= 'h28) begin
        k = eff_kind(bi);
        if (k != {1'b0, pcb_pkg::KIND_NONE}) begin
          cur = (k == KIND_HIGH) ? m_high[bi-1] : (bar_value(bi) & bar_mask(bi));
          if (size == 4 && bo == 0) cur = data;
          else begin
            m = ((size == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * size)) - 32'd1)) << (8 * bo);
            cur = (cur & ~m) | ((data << (8 * bo)) & m);
          end
          if (k == KIND_HIGH) m_high[bi-1] = cur;
          else m_low[bi] = cur & bar_mask(bi);
        end
      end else begin
        old = m_cmd;
        for (int i = 0; i < size; i++) begin
          case (off + i)
            4: m_cmd[7:0] = data[8*i +: 8];
            5: m_cmd[15:8] = data[8*i +: 8];
            'h0C: m_scratch[0] = data[8*i +: 8];
            'h0D: m_scratch[1] = data[8*i +: 8];
            'h3C: m_scratch[2] = data[8*i +: 8];
            default: ;
          endcase
        end
        // Command change: walk memory BARs in index order.
        if (old != m_cmd) begin
          for (int i = 0; i < pcb_pkg::NumBars; i++) begin
            k = eff_kind(i);
            if (k != {1'b0, pcb_pkg::KIND_MEM32} && k != {1'b0, pcb_pkg::KIND_MEM64})
              continue;
            gpa = {32'd0, m_low[i] & 32'hFFFF_FFF0};
            if (k == {1'b0, pcb_pkg::KIND_MEM64}) gpa[63:32] = m_high[i];
            want = m_cmd[1] && gpa != 0;
            if (want && !m_mapped[i]) begin
              m_mapped[i] = 1'b1;
              m_maddr[i] = gpa;
              res.push_back(event_beat(pcb_pkg::EV_MAP, i, gpa, m_slogs[5*i +: 5]));
            end else if (!want && m_mapped[i]) begin
              m_mapped[i] = 1'b0;
              res.push_back(event_beat(pcb_pkg::EV_UNMAP, i, '0, '0));
            end else if (want && m_maddr[i] != gpa) begin
              res.push_back(event_beat(pcb_pkg::EV_UNMAP, i, '0, '0));
              m_maddr[i] = gpa;
              res.push_back(event_beat(pcb_pkg::EV_MAP, i, gpa, m_slogs[5*i +: 5]));
            end
          end
        end
      end
    end
    if (res.size() == 0) res.push_back('0);
    res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_beats.push_back(res[i]);
  endtask

  // Checks each result beat against the oldest expectation.
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_valid) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = expected_beats.pop_front();
        if (out_read_data !== e.rdata) begin
          $error("read_data exp %h got %h", e.rdata, out_read_data); errors++;
        end
        if (out_event_kind !== e.kind) begin
          $error("event_kind exp %0d got %0d", e.kind, out_event_kind); errors++;
        end
        if (out_event_bar !== e.bar) begin
          $error("event_bar exp %0d got %0d", e.bar, out_event_bar); errors++;
        end
        if (out_event_address !== e.addr) begin
          $error("event_address exp %h got %h", e.addr, out_event_address); errors++;
        end
        if (out_event_size_log !== e.slog) begin
          $error("event_size_log exp %0d got %0d", e.slog, out_event_size_log); errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_last); errors++;
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one access beat and records its prediction.
  task automatic send_access(logic wr, int off, int size, logic [31:0] data);
    start <= 1'b1;
    in_command <= wr;
    in_byte_offset <= off[7:0];
    in_access_size <= size[2:0];
    in_write_data <= data;
    do @(posedge clk); while (busy);
    predict_access(wr, off, size, data);
    start <= 1'b0;
    // The block stays busy after an accept, so this edge costs no throughput.
    @(posedge clk);
    idle_gap();
  endtask

  task automatic wait_drained();
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      pcb_pkg::REG_VDID: m_vdid = v;
      pcb_pkg::REG_SSID: m_ssid = v;
      pcb_pkg::REG_CLRV: m_clrv = v;
      pcb_pkg::REG_IPIN: m_ipin = v[7:0];
      pcb_pkg::REG_KIND: m_kinds = v[11:0];
      pcb_pkg::REG_SLOG: m_slogs = v[29:0];
      pcb_pkg::REG_PREF: m_pref = v[5:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_layout(logic [31:0] vd, logic [31:0] ss, logic [31:0] cr,
                            logic [7:0] ip, logic [11:0] kd, logic [29:0] sl,
                            logic [5:0] pf);
    wait_drained();
    cfg_write(pcb_pkg::REG_VDID, vd);
    cfg_write(pcb_pkg::REG_SSID, ss);
    cfg_write(pcb_pkg::REG_CLRV, cr);
    cfg_write(pcb_pkg::REG_IPIN, {24'd0, ip});
    cfg_write(pcb_pkg::REG_KIND, {20'd0, kd});
    cfg_write(pcb_pkg::REG_SLOG, {2'd0, sl});
    cfg_write(pcb_pkg::REG_PREF, {26'd0, pf});
  endtask

  function automatic int rand_size();
    int s;
    s = $urandom_range(0, 19);
    if (s < 6) return 1;
    if (s < 12) return 2;
    if (s < 18) return 4;
    return (s == 18) ? 0 : $urandom_range(5, 7);
  endfunction

  // Header bytes, sizes, window edges and the end of the space.
  task automatic test_directed_header();
    send_access(1'b0, 0, 4, '0);
    send_access(1'b0, 8, 4, '0);
    send_access(1'b0, 'h2C, 4, '0);
    send_access(1'b0, 'h3C, 2, '0);
    send_access(1'b1, 'h0C, 2, 32'hFFFF_A55A);
    send_access(1'b1, 'h3C, 4, 32'hFFFF_FFFF);
    send_access(1'b0, 'h0C, 4, '0);
    send_access(1'b0, 'h3C, 4, '0);
    send_access(1'b0, 'hFF, 1, '0);
    send_access(1'b0, 'hFE, 4, '0);
    send_access(1'b1, 'hFE, 4, 32'hFFFF_FFFF);
    send_access(1'b0, 4, 3, '0);
    send_access(1'b1, 4, 0, 32'hFFFF_FFFF);
    send_access(1'b0, 'h12, 4, '0);
    send_access(1'b0, 'h26, 2, '0);
  endtask

  // BAR sizing, high halves and command driven map events.
  task automatic test_directed_bars();
    send_access(1'b1, 'h10, 4, 32'hFFFF_FFFF);
    send_access(1'b0, 'h10, 4, '0);
    send_access(1'b1, 'h14, 4, 32'h8000_0000);
    send_access(1'b1, 'h18, 4, 32'h1234_5678);
    send_access(1'b1, 'h1C, 2, 32'h0000_ABCD);
    send_access(1'b1, 'h1E, 1, 32'h0000_0011);
    send_access(1'b0, 'h1C, 4, '0);
    send_access(1'b1, 'h24, 4, 32'hFFFF_FFF0);
    send_access(1'b1, 4, 2, 32'h0000_0003);
    send_access(1'b1, 'h18, 4, 32'h2000_0000);
    send_access(1'b1, 4, 1, 32'h0000_0007);
    send_access(1'b1, 4, 2, 32'h0000_0000);
    send_access(1'b0, 4, 2, '0);
  endtask

  // Mostly well-formed BAR programming mixed with command toggles and random accesses.
  task automatic test_random_traffic(int count);
    int off, sz;
    logic [31:0] d;
    for (int n = 0; n < count; n++) begin
      d = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          off = 'h10 + 4 * $urandom_range(0, 5);
          send_access(1'b1, off, 4, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : d);
        end
        3, 4: send_access(1'b1, 4, $urandom_range(0, 1) ? 2 : 1, d);
        5, 6: begin
          off = 'h10 + $urandom_range(0, 23);
          send_access($urandom_range(0, 1), off, rand_size(), d);
        end
        default: begin
          sz = rand_size();
          send_access($urandom_range(0, 1), $urandom_range(0, 255), sz, d);
        end
      endcase
      if (n == count / 2) wait_drained();
    end
  endtask

  initial begin
    m_cmd = '0;
    foreach (m_low[i]) begin
      m_low[i] = '0; m_high[i] = '0; m_mapped[i] = 1'b0; m_maddr[i] = '0;
    end
    foreach (m_scratch[i]) m_scratch[i] = '0;
    m_vdid = '0; m_ssid = '0; m_clrv = '0; m_ipin = '0;
    m_kinds = '0; m_slogs = '0; m_pref = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
               {pcb_pkg::KIND_MEM32, pcb_pkg::KIND_NONE, pcb_pkg::KIND_MEM64,
                pcb_pkg::KIND_MEM32, pcb_pkg::KIND_MEM32, pcb_pkg::KIND_IO},
               {5'd31, 5'd0, 5'd20, 5'd4, 5'd12, 5'd2}, 6'b111111);
    test_directed_header();
    test_directed_bars();
    test_random_traffic(100);

    set_layout(32'h0, 32'h0, 32'h0, 8'h00, 12'h0, 30'h0, 6'h0);
    test_random_traffic(30);

    set_layout($urandom(), $urandom(), $urandom(), 8'h01,
               {pcb_pkg::KIND_MEM64, pcb_pkg::KIND_MEM64, pcb_pkg::KIND_MEM32,
                pcb_pkg::KIND_MEM64, pcb_pkg::KIND_IO, pcb_pkg::KIND_MEM64},
               {5'd8, 5'd0, 5'd16, 5'd0, 5'd3, 5'd5}, 6'b010101);
    test_random_traffic(95);

    set_layout($urandom(), $urandom(), $urandom(), 8'($urandom()),
               12'($urandom()), 30'($urandom()), 6'($urandom()));
    test_random_traffic(95);

    wait_drained();
    if (errors == 0) $display("pci_config_space_bars_tb: clean");
    else $display("pci_config_space_bars_tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
